[hdl/spg_pkg.sv]
// Shared types, constants and codes for the step pulse generator.
`timescale 1ns / 1ps
package spg_pkg;

  // Field widths
  localparam int FREQ_W  = 19;
  localparam int WD_W    = 18;
  localparam int CNT_W   = 32;
  localparam int REQ_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int LBIT_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int STEP_W  = 2;
  localparam int DCNT_W  = 5;

  // Timing constants in ticks
  localparam logic [WD_W-1:0]   WATCHDOG_TICKS = 18'd250000;
  localparam logic [FREQ_W-1:0] IDLE_TICKS     = 19'd15000;
  localparam logic [FREQ_W-1:0] HALF_NUM       = 19'd500000;

  // Status bit that arrives inverted
  localparam logic [BYTE_W-1:0] STATUS_INV = 8'h80;

  // Command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_SETF  = 3'd1;
  localparam logic [2:0] CMD_DIR   = 3'd2;
  localparam logic [2:0] CMD_FLAP  = 3'd3;
  localparam logic [2:0] CMD_START = 3'd4;
  localparam logic [2:0] CMD_STOP  = 3'd5;

  // Flap choices
  localparam logic [1:0] FLAP_CLOSE = 2'd0;
  localparam logic [1:0] FLAP_IN    = 2'd1;
  localparam logic [1:0] FLAP_OUT   = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MIN_FREQ   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MAX_FREQ   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_START_BIT  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_END_BIT    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_CLOSE_BYTE = 3'd4;
  localparam logic [CIDX_W-1:0] REG_IN_BYTE    = 3'd5;
  localparam logic [CIDX_W-1:0] REG_OUT_BYTE   = 3'd6;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SETF,
    OP_DIR,
    OP_FLAP,
    OP_START,
    OP_STOP,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    PH_BOUND,
    PH_LOW,
    PH_HIGH,
    PH_WAIT
  } phase_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } bk_state_t;

  // Decoded word passed from front to back
  typedef struct packed {
    op_t               op;
    logic [FREQ_W-1:0] freq;
    logic              reverse;
    logic              flap_we;
    logic [BYTE_W-1:0] flap;
    logic              start_hit;
    logic              end_hit;
  } q_entry_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FREQ_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/spg_front.sv]
// Front end: configuration registers, command decode, limit and frequency clamp.
`timescale 1ns / 1ps
module spg_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [spg_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [spg_pkg::FREQ_W-1:0]  cfg_data,
  input  logic [2:0]                  in_command,
  input  logic [spg_pkg::REQ_W-1:0]   in_frequency_request,
  input  logic                        in_reverse,
  input  logic [1:0]                  in_flaps_choice,
  input  logic [spg_pkg::BYTE_W-1:0]  in_status_byte,
  output spg_pkg::q_entry_t           entry
);
  import spg_pkg::*;

  logic [FREQ_W-1:0] min_freq_r, max_freq_r;
  logic [LBIT_W-1:0] start_bit_r, end_bit_r;
  logic [BYTE_W-1:0] close_byte_r, in_byte_r, out_byte_r;

  logic [BYTE_W-1:0] status;
  logic [REQ_W-1:0]  req_u;
  logic [REQ_W-1:0]  quarter_w, min_w, max_w;
  logic              req_pos;
  logic [FREQ_W-1:0] freq_clamped;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_freq_r   <= 19'd100;
      max_freq_r   <= 19'd10000;
      start_bit_r  <= 3'd0;
      end_bit_r    <= 3'd1;
      close_byte_r <= '0;
      in_byte_r    <= '0;
      out_byte_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_FREQ:   min_freq_r   <= cfg_data;
        REG_MAX_FREQ:   max_freq_r   <= cfg_data;
        REG_START_BIT:  start_bit_r  <= cfg_data[LBIT_W-1:0];
        REG_END_BIT:    end_bit_r    <= cfg_data[LBIT_W-1:0];
        REG_CLOSE_BYTE: close_byte_r <= cfg_data[BYTE_W-1:0];
        REG_IN_BYTE:    in_byte_r    <= cfg_data[BYTE_W-1:0];
        REG_OUT_BYTE:   out_byte_r   <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample limit switches from the corrected status
  assign status = in_status_byte ^ STATUS_INV;

  // Clamp the request; positive requests compare as unsigned
  assign req_u     = in_frequency_request;
  assign req_pos   = !req_u[REQ_W-1] && (req_u != '0);
  assign quarter_w = {{(REQ_W-FREQ_W+2){1'b0}}, min_freq_r[FREQ_W-1:2]};
  assign min_w     = {{(REQ_W-FREQ_W){1'b0}}, min_freq_r};
  assign max_w     = {{(REQ_W-FREQ_W){1'b0}}, max_freq_r};

  always_comb begin
    priority if (!req_pos || req_u <= quarter_w) freq_clamped = '0;
    else if (req_u < min_w)                      freq_clamped = min_freq_r;
    else if (req_u > max_w)                      freq_clamped = max_freq_r;
    else                                         freq_clamped = req_u[FREQ_W-1:0];
  end

  // Decode the command into a word for the back end
  always_comb begin
    entry.freq      = freq_clamped;
    entry.reverse   = in_reverse;
    entry.start_hit = status[start_bit_r];
    entry.end_hit   = status[end_bit_r];
    entry.flap_we   = 1'b1;
    unique case (in_flaps_choice)
      FLAP_CLOSE: entry.flap = close_byte_r;
      FLAP_IN:    entry.flap = in_byte_r;
      FLAP_OUT:   entry.flap = out_byte_r;
      default: begin
        entry.flap    = close_byte_r;
        entry.flap_we = 1'b0;
      end
    endcase
    unique case (in_command)
      CMD_TICK:  entry.op = OP_TICK;
      CMD_SETF:  entry.op = OP_SETF;
      CMD_DIR:   entry.op = OP_DIR;
      CMD_FLAP:  entry.op = OP_FLAP;
      CMD_START: entry.op = OP_START;
      CMD_STOP:  entry.op = OP_STOP;
      default:   entry.op = OP_NOP;
    endcase
  end

endmodule

[hdl/spg_queue.sv]
// Two-entry queue of decoded words between front and back.
`timescale 1ns / 1ps
module spg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spg_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output spg_pkg::q_entry_t head
);
  import spg_pkg::*;

  q_entry_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = count_r[1];
  assign not_empty = count_r != 2'd0;
  assign head      = mem_r[rd_ptr_r];

  // Store pushed word
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

[hdl/spg_div.sv]
// Restoring divider: half period = numerator / frequency, one bit per cycle.
`timescale 1ns / 1ps
module spg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  spg_pkg::div_req_t req,
  output spg_pkg::div_rsp_t rsp
);
  import spg_pkg::*;

  logic              busy_r, done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [FREQ_W-1:0] num_r, rem_r, div_r;
  logic [FREQ_W:0]   rem_sh, rem_sub;
  logic              q_bit;

  // One restoring step
  assign rem_sh  = {rem_r, num_r[FREQ_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign q_bit   = !rem_sub[FREQ_W];

  assign rsp.done     = done_r;
  assign rsp.quotient = num_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(FREQ_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in where the numerator shifts out
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= HALF_NUM;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      num_r <= {num_r[FREQ_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
    end
  end

endmodule

[hdl/spg_back.sv]
// Back end: generator state, step phases, watchdog and result register.
`timescale 1ns / 1ps
module spg_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  spg_pkg::q_entry_t          q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [spg_pkg::STEP_W-1:0] out_port_data,
  output logic [spg_pkg::BYTE_W-1:0] out_flap_byte,
  output logic [spg_pkg::CNT_W-1:0]  out_pulse_count,
  output logic [spg_pkg::FREQ_W-1:0] out_frequency_in_use,
  output logic                       out_start_limit_hit,
  output logic                       out_end_limit_hit,
  output logic                       out_running
);
  import spg_pkg::*;

  bk_state_t         state_r, state_nxt;
  logic              run_r, run_nxt;
  logic              bw_r, bw_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [FREQ_W-1:0] half_r, half_nxt;
  phase_t            phase_r, phase_nxt;
  logic [FREQ_W-1:0] timer_r, timer_nxt;
  logic [WD_W-1:0]   wd_r, wd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] flap_r, flap_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              shit_r, shit_nxt;
  logic              ehit_r, ehit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free, load_out, expired, blocked;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  spg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free = !out_valid_r || out_ready;
  assign expired  = wd_r >= WATCHDOG_TICKS;

  // Next state of the generator
  always_comb begin
    state_nxt   = state_r;
    run_nxt     = run_r;
    bw_nxt      = bw_r;
    freq_nxt    = freq_r;
    half_nxt    = half_r;
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    wd_nxt      = wd_r;
    cnt_nxt     = cnt_r;
    flap_nxt    = flap_r;
    step_nxt    = step_r;
    shit_nxt    = shit_r;
    ehit_nxt    = ehit_r;
    q_pop       = 1'b0;
    load_out    = 1'b0;
    blocked     = 1'b0;
    div_req.start   = 1'b0;
    div_req.divisor = q_head.freq;
    unique case (state_r)
      BK_IDLE: begin
        if (q_not_empty && out_free) begin
          q_pop    = 1'b1;
          shit_nxt = q_head.start_hit;
          ehit_nxt = q_head.end_hit;
          load_out = 1'b1;
          unique case (q_head.op)
            OP_TICK: begin
              if (run_r) begin
                // Close the running phase
                if (phase_nxt != PH_BOUND && timer_nxt == '0) begin
                  if (phase_nxt == PH_LOW) begin
                    phase_nxt = PH_HIGH;
                    timer_nxt = half_r;
                    step_nxt  = {bw_r, 1'b1};
                  end else begin
                    if (phase_nxt == PH_HIGH) cnt_nxt = cnt_r + 1'b1;
                    phase_nxt = PH_BOUND;
                  end
                end
                // Start the next period or hold off
                if (phase_nxt == PH_BOUND) begin
                  blocked = expired || (bw_r && q_head.start_hit) ||
                            (!bw_r && q_head.end_hit) ||
                            freq_r == '0 || half_r == '0;
                  if (blocked) begin
                    phase_nxt = PH_WAIT;
                    timer_nxt = IDLE_TICKS;
                  end else begin
                    phase_nxt = PH_LOW;
                    timer_nxt = half_r;
                    step_nxt  = {bw_r, 1'b0};
                  end
                end
                if (timer_nxt != '0) timer_nxt = timer_nxt - 1'b1;
                if (!expired) wd_nxt = wd_r + 1'b1;
              end
            end
            OP_SETF: begin
              wd_nxt   = '0;
              freq_nxt = q_head.freq;
              if (q_head.freq == '0) begin
                half_nxt = '0;
              end else begin
                // Hold the result until the divider finishes
                load_out      = 1'b0;
                div_req.start = 1'b1;
                state_nxt     = BK_DIV;
              end
            end
            OP_DIR: bw_nxt = q_head.reverse;
            OP_FLAP: begin
              if (q_head.flap_we) flap_nxt = q_head.flap;
            end
            OP_START: begin
              freq_nxt  = '0;
              half_nxt  = '0;
              cnt_nxt   = '0;
              wd_nxt    = '0;
              phase_nxt = PH_BOUND;
              timer_nxt = '0;
              run_nxt   = 1'b1;
            end
            OP_STOP: begin
              run_nxt   = 1'b0;
              phase_nxt = PH_BOUND;
              timer_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          half_nxt  = div_rsp.quotient;
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      run_r       <= 1'b0;
      bw_r        <= 1'b0;
      freq_r      <= '0;
      half_r      <= '0;
      phase_r     <= PH_BOUND;
      timer_r     <= '0;
      wd_r        <= '0;
      cnt_r       <= '0;
      flap_r      <= '0;
      step_r      <= '0;
      shit_r      <= 1'b0;
      ehit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      bw_r        <= bw_nxt;
      freq_r      <= freq_nxt;
      half_r      <= half_nxt;
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      wd_r        <= wd_nxt;
      cnt_r       <= cnt_nxt;
      flap_r      <= flap_nxt;
      step_r      <= step_nxt;
      shit_r      <= shit_nxt;
      ehit_r      <= ehit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register: load the state as left by this word
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_port_data        <= step_nxt;
      out_flap_byte        <= flap_nxt;
      out_pulse_count      <= cnt_nxt;
      out_frequency_in_use <= freq_nxt;
      out_start_limit_hit  <= shit_nxt;
      out_end_limit_hit    <= ehit_nxt;
      out_running          <= run_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/step_pulse_generator_with_limits.sv]
// Top level of the stepper step/direction pulse generator with limit switches.
//
//  Channel | Handshake              | Word
//  --------+------------------------+---------------------------------------------
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in_valid / in_ready    | command, frequency_request, reverse, flaps, status
//  out     | out_valid / out_ready  | port_data, flap_byte, pulse_count, freq, hits, running
//
// A result word becomes valid after its input word is accepted: the queue takes the
// decoded word at the accepting edge, and the back end pops it, when idle and the result
// register is free, and loads the result register. Set frequency with a nonzero frequency
// also waits for the bit-serial half period divider (19 quotient bit steps, one per cycle).
// Reset (rst_n low, synchronous) restores register defaults and clears all generator state.
// in_ready drops only while the two-entry queue is full; the back end stalls on out_ready.
// cfg_ready is always high.
`timescale 1ns / 1ps
module step_pulse_generator_with_limits (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [spg_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [spg_pkg::FREQ_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_command,
  input  logic [spg_pkg::REQ_W-1:0]   in_frequency_request,
  input  logic                        in_reverse,
  input  logic [1:0]                  in_flaps_choice,
  input  logic [spg_pkg::BYTE_W-1:0]  in_status_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [spg_pkg::STEP_W-1:0]  out_port_data,
  output logic [spg_pkg::BYTE_W-1:0]  out_flap_byte,
  output logic [spg_pkg::CNT_W-1:0]   out_pulse_count,
  output logic [spg_pkg::FREQ_W-1:0]  out_frequency_in_use,
  output logic                        out_start_limit_hit,
  output logic                        out_end_limit_hit,
  output logic                        out_running
);
  import spg_pkg::*;

  q_entry_t front_entry, q_head;
  logic     q_full, q_not_empty, q_pop, push;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  spg_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_command           (in_command),
    .in_frequency_request (in_frequency_request),
    .in_reverse           (in_reverse),
    .in_flaps_choice      (in_flaps_choice),
    .in_status_byte       (in_status_byte),
    .entry                (front_entry)
  );

  spg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  spg_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_not_empty          (q_not_empty),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_port_data        (out_port_data),
    .out_flap_byte        (out_flap_byte),
    .out_pulse_count      (out_pulse_count),
    .out_frequency_in_use (out_frequency_in_use),
    .out_start_limit_hit  (out_start_limit_hit),
    .out_end_limit_hit    (out_end_limit_hit),
    .out_running          (out_running)
  );

endmodule

[tb/sv/step_pulse_checker.sv]
// Checker for the step pulse generator: predicts every result word and compares it.
`timescale 1ns / 1ps
module step_pulse_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [spg_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [spg_pkg::FREQ_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [2:0]                  in_command,
  input  logic [spg_pkg::REQ_W-1:0]   in_frequency_request,
  input  logic                        in_reverse,
  input  logic [1:0]                  in_flaps_choice,
  input  logic [spg_pkg::BYTE_W-1:0]  in_status_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [spg_pkg::STEP_W-1:0]  out_port_data,
  input  logic [spg_pkg::BYTE_W-1:0]  out_flap_byte,
  input  logic [spg_pkg::CNT_W-1:0]   out_pulse_count,
  input  logic [spg_pkg::FREQ_W-1:0]  out_frequency_in_use,
  input  logic                        out_start_limit_hit,
  input  logic                        out_end_limit_hit,
  input  logic                        out_running,
  output int                          fail_count,
  output int                          words_pending
);
  import spg_pkg::*;

  localparam int unsigned WDOG_LIMIT     = 250000;
  localparam int unsigned WAIT_TICKS     = 15000;
  localparam int unsigned HALF_NUMERATOR = 500000;

  typedef struct packed {
    logic [STEP_W-1:0] port_data;
    logic [BYTE_W-1:0] flap_byte;
    logic [CNT_W-1:0]  pulse_count;
    logic [FREQ_W-1:0] frequency_in_use;
    logic              start_hit;
    logic              end_hit;
    logic              running;
  } result_t;

  result_t expected_q[$];
  result_t want_word;
  int      mismatches = 0;

  // Mirrored settings
  logic [FREQ_W-1:0] min_freq, max_freq;
  logic [2:0]        start_sel, end_sel;
  logic [BYTE_W-1:0] close_byte, in_byte, out_byte;

  // Predicted generator state
  logic              run_on, backward;
  logic [FREQ_W-1:0] freq, half, ph_timer;
  phase_t            ph;
  logic [WD_W-1:0]   wdog;
  logic [CNT_W-1:0]  pulses;
  logic [BYTE_W-1:0] flap;
  logic [STEP_W-1:0] step;

  assign fail_count = mismatches;

  function automatic void restore_defaults();
    min_freq = 19'd100;
    max_freq = 19'd10000;
    start_sel = 3'd0;
    end_sel = 3'd1;
    close_byte = '0;
    in_byte = '0;
    out_byte = '0;
    run_on = 1'b0;
    backward = 1'b0;
    freq = '0;
    half = '0;
    ph = PH_BOUND;
    ph_timer = '0;
    wdog = '0;
    pulses = '0;
    flap = '0;
    step = '0;
    expected_q.delete();
  endfunction

  // Clamp the request and derive the half period; restart the watchdog
  function automatic void load_frequency(logic [REQ_W-1:0] raw);
    longint            req;
    longint            quarter;
    logic [FREQ_W-1:0] f;
    req = longint'($signed(raw));
    quarter = longint'(min_freq / 4);
    wdog = '0;
    if (req <= quarter || req <= 0) begin
      freq = '0;
      half = '0;
      return;
    end
    if (req < longint'(min_freq)) f = min_freq;
    else if (req > longint'(max_freq)) f = max_freq;
    else f = raw[FREQ_W-1:0];
    freq = f;
    half = (f != 0) ? FREQ_W'(HALF_NUMERATOR / f) : '0;
  endfunction

  // Advance the generator by one microsecond
  function automatic void advance_tick(logic s_hit, logic e_hit);
    logic expired;
    expired = (wdog >= WDOG_LIMIT);
    if (ph != PH_BOUND && ph_timer == 0) begin
      if (ph == PH_LOW) begin
        ph = PH_HIGH;
        ph_timer = half;
        step = {backward, 1'b1};
      end else begin
        if (ph == PH_HIGH) pulses = pulses + 1;
        ph = PH_BOUND;
      end
    end
    if (ph == PH_BOUND) begin
      if (expired || (backward && s_hit) || (!backward && e_hit) || freq == 0 || half == 0) begin
        ph = PH_WAIT;
        ph_timer = FREQ_W'(WAIT_TICKS);
      end else begin
        ph = PH_LOW;
        ph_timer = half;
        step = {backward, 1'b0};
      end
    end
    if (ph_timer != 0) ph_timer = ph_timer - 1'b1;
    if (!expired) wdog = wdog + 1'b1;
  endfunction

  function automatic void predict_word(logic [2:0] cmd, logic [REQ_W-1:0] req, logic rev,
                                       logic [1:0] choice, logic [BYTE_W-1:0] raw_status);
    logic [BYTE_W-1:0] st;
    logic              s_hit;
    logic              e_hit;
    result_t           r;
    st = raw_status ^ 8'h80;
    s_hit = st[start_sel];
    e_hit = st[end_sel];
    case (cmd)
      CMD_TICK: if (run_on) advance_tick(s_hit, e_hit);
      CMD_SETF: load_frequency(req);
      CMD_DIR: backward = rev;
      CMD_FLAP: begin
        case (choice)
          FLAP_CLOSE: flap = close_byte;
          FLAP_IN: flap = in_byte;
          FLAP_OUT: flap = out_byte;
          default: ;
        endcase
      end
      CMD_START: begin
        freq = '0;
        half = '0;
        pulses = '0;
        wdog = '0;
        ph = PH_BOUND;
        ph_timer = '0;
        run_on = 1'b1;
      end
      CMD_STOP: begin
        run_on = 1'b0;
        ph = PH_BOUND;
        ph_timer = '0;
      end
      default: ;
    endcase
    r.port_data = step;
    r.flap_byte = flap;
    r.pulse_count = pulses;
    r.frequency_in_use = freq;
    r.start_hit = s_hit;
    r.end_hit = e_hit;
    r.running = run_on;
    expected_q.push_back(r);
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      restore_defaults();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_FREQ: min_freq = cfg_data;
          REG_MAX_FREQ: max_freq = cfg_data;
          REG_START_BIT: start_sel = cfg_data[2:0];
          REG_END_BIT: end_sel = cfg_data[2:0];
          REG_CLOSE_BYTE: close_byte = cfg_data[BYTE_W-1:0];
          REG_IN_BYTE: in_byte = cfg_data[BYTE_W-1:0];
          REG_OUT_BYTE: out_byte = cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
      // Compare the delivered word against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          want_word = expected_q.pop_front();
          check_field("port_data", 64'(want_word.port_data), 64'(out_port_data));
          check_field("flap_byte", 64'(want_word.flap_byte), 64'(out_flap_byte));
          check_field("pulse_count", 64'(want_word.pulse_count), 64'(out_pulse_count));
          check_field("frequency_in_use", 64'(want_word.frequency_in_use),
                      64'(out_frequency_in_use));
          check_field("start_limit_hit", 64'(want_word.start_hit), 64'(out_start_limit_hit));
          check_field("end_limit_hit", 64'(want_word.end_hit), 64'(out_end_limit_hit));
          check_field("running", 64'(want_word.running), 64'(out_running));
        end
      end
      if (in_valid && in_ready) begin
        predict_word(in_command, in_frequency_request, in_reverse, in_flaps_choice,
                     in_status_byte);
      end
    end
    words_pending <= expected_q.size();
  end

endmodule

[tb/sv/tb_step_pulse_generator_with_limits.sv]
// Testbench top for the step pulse generator: clock, reset, word stimulus and verdict.
`timescale 1ns / 1ps
module tb_step_pulse_generator_with_limits;
  import spg_pkg::*;

  localparam int LIMIT_CYCLES    = 200000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WORDS_PER_PHASE = 80;
  localparam int RUN_TICKS       = 100;

  // Selectors the block ignores
  localparam logic [2:0]        CMD_SPARE_A = 3'd6;
  localparam logic [2:0]        CMD_SPARE_B = 3'd7;
  localparam logic [1:0]        FLAP_NONE   = 2'd3;
  localparam logic [CIDX_W-1:0] REG_SPARE   = 3'd7;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [FREQ_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_command = CMD_TICK;
  logic [REQ_W-1:0]    in_frequency_request = '0;
  logic                in_reverse = 1'b0;
  logic [1:0]          in_flaps_choice = FLAP_CLOSE;
  logic [BYTE_W-1:0]   in_status_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STEP_W-1:0]   out_port_data;
  logic [BYTE_W-1:0]   out_flap_byte;
  logic [CNT_W-1:0]    out_pulse_count;
  logic [FREQ_W-1:0]   out_frequency_in_use;
  logic                out_start_limit_hit;
  logic                out_end_limit_hit;
  logic                out_running;

  int fail_count;
  int words_pending;
  int cycle_count = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Current settings, kept to shape the stimulus
  int unsigned min_f = 100;
  int unsigned max_f = 10000;
  logic [2:0]  start_bit = 3'd0;
  logic [2:0]  end_bit = 3'd1;

  step_pulse_generator_with_limits dut (.*);

  step_pulse_checker pulse_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: stall at random
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [FREQ_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input int unsigned lo, input int unsigned hi,
                               input logic [2:0] sb, input logic [2:0] eb,
                               input logic [7:0] cb, input logic [7:0] ib,
                               input logic [7:0] ob);
    min_f = lo;
    max_f = hi;
    start_bit = sb;
    end_bit = eb;
    write_reg(REG_MIN_FREQ, FREQ_W'(lo));
    write_reg(REG_MAX_FREQ, FREQ_W'(hi));
    write_reg(REG_START_BIT, FREQ_W'(sb));
    write_reg(REG_END_BIT, FREQ_W'(eb));
    write_reg(REG_CLOSE_BYTE, FREQ_W'(cb));
    write_reg(REG_IN_BYTE, FREQ_W'(ib));
    write_reg(REG_OUT_BYTE, FREQ_W'(ob));
    write_reg(REG_SPARE, FREQ_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Present one word, idling first at random; hold it until accepted
  task automatic send_word(input logic [2:0] cmd, input logic [31:0] req, input logic rev,
                           input logic [1:0] choice, input logic [7:0] status);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_frequency_request <= req;
    in_reverse <= rev;
    in_flaps_choice <= choice;
    in_status_byte <= status;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Hold off input until every predicted word has been delivered
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  // Random status byte with both limit switches released
  function automatic logic [7:0] clear_status();
    logic [7:0] s;
    s = 8'($urandom_range(255));
    s[start_bit] = (start_bit == 3'd7);
    s[end_bit] = (end_bit == 3'd7);
    return s;
  endfunction

  function automatic logic [31:0] pick_request();
    int q;
    q = int'(min_f / 4);
    case ($urandom_range(9))
      0: return $urandom;
      1: return q - 1 + int'($urandom_range(2));
      2: return int'(max_f) + int'($urandom_range(1000));
      3: return -int'($urandom_range(1000));
      4: return int'($urandom_range(min_f));
      default: return (min_f <= max_f) ? $urandom_range(max_f, min_f)
                                       : $urandom_range(min_f, max_f);
    endcase
  endfunction

  // Mostly ticks with released switches, plus commands and noise
  task automatic send_random_word();
    logic [2:0]  cmd;
    logic [31:0] req;
    logic [7:0]  status;
    int unsigned pick;
    pick = $urandom_range(99);
    req = $urandom;
    status = 8'($urandom_range(255));
    if (pick < 62) begin
      cmd = CMD_TICK;
      if ($urandom_range(9) != 0) status = clear_status();
    end else if (pick < 72) begin
      cmd = CMD_SETF;
      req = pick_request();
    end else if (pick < 78) cmd = CMD_DIR;
    else if (pick < 84) cmd = CMD_FLAP;
    else if (pick < 87) cmd = CMD_START;
    else if (pick < 90) cmd = CMD_STOP;
    else if (pick < 94) cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
    else cmd = 3'($urandom_range(7));
    send_word(cmd, req, 1'($urandom_range(1)), 2'($urandom_range(3)), status);
  endtask

  // Start, pick direction and frequency, then run
  task automatic run_session();
    send_word(CMD_START, $urandom, 1'($urandom_range(1)), 2'($urandom_range(3)),
              8'($urandom_range(255)));
    if ($urandom_range(3) != 0) begin
      send_word(CMD_DIR, $urandom, 1'($urandom_range(1)), 2'($urandom_range(3)),
                8'($urandom_range(255)));
    end
    send_word(CMD_SETF, pick_request(), 1'($urandom_range(1)), 2'($urandom_range(3)),
              8'($urandom_range(255)));
    repeat ($urandom_range(30, 5)) send_random_word();
  endtask

  initial begin
    int phase_start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words
    load_settings(100, 500000, 3'd0, 3'd1, 8'h00, 8'hFF, 8'hA5);
    send_word(CMD_TICK, $urandom, 1'b0, FLAP_CLOSE, 8'h80);
    send_word(CMD_FLAP, $urandom, 1'b0, FLAP_CLOSE, 8'h80);
    send_word(CMD_FLAP, $urandom, 1'b0, FLAP_IN, 8'h80);
    send_word(CMD_FLAP, $urandom, 1'b0, FLAP_OUT, 8'h80);
    send_word(CMD_FLAP, $urandom, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_SETF, 32'd5000, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_DIR, $urandom, 1'b1, FLAP_NONE, 8'h80);
    send_word(CMD_START, $urandom, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_SETF, 32'h8000_0000, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_SETF, 32'd0, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_SETF, 32'd25, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_SETF, 32'd26, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_SETF, 32'h7FFF_FFFF, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_DIR, $urandom, 1'b0, FLAP_NONE, 8'h80);
    repeat (6) send_word(CMD_TICK, $urandom, 1'b1, FLAP_NONE, 8'h80);
    send_word(CMD_TICK, $urandom, 1'b0, FLAP_NONE, 8'h7F);
    send_word(CMD_SPARE_A, $urandom, 1'b1, FLAP_IN, 8'hFF);
    send_word(CMD_SPARE_B, $urandom, 1'b1, FLAP_OUT, 8'h00);
    send_word(CMD_STOP, $urandom, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_TICK, $urandom, 1'b0, FLAP_NONE, 8'h80);

    // Idle wait on the end switch, restart, then a run of short pulses
    send_word(CMD_START, $urandom, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_SETF, 32'd10000, 1'b0, FLAP_NONE, 8'h80);
    repeat (30) send_word(CMD_TICK, $urandom, 1'b0, FLAP_NONE, 8'h7F);
    send_word(CMD_START, $urandom, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_SETF, 32'd250000, 1'b0, FLAP_NONE, 8'h80);
    repeat (RUN_TICKS) send_word(CMD_TICK, $urandom, 1'b0, FLAP_NONE, 8'h80);
    send_word(CMD_SETF, 32'd20000, 1'b0, FLAP_NONE, 8'h80);
    repeat (20) send_word(CMD_TICK, $urandom, 1'b0, FLAP_NONE, 8'h80);

    // Random phases, each under its own settings and idling
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: load_settings(1, 500000, 3'd0, 3'd7, 8'h00, 8'hFF, 8'($urandom_range(255)));
        1: load_settings(500000, 500000, 3'd7, 3'd0, 8'hFF, 8'h00, 8'($urandom_range(255)));
        2: load_settings(1, 1, 3'($urandom_range(7)), 3'($urandom_range(7)),
                         8'($urandom_range(255)), 8'($urandom_range(255)), 8'h00);
        3: load_settings(400000, 1000, 3'($urandom_range(7)), 3'($urandom_range(7)),
                         8'($urandom_range(255)), 8'($urandom_range(255)), 8'hFF);
        4: load_settings(100, 0, 3'($urandom_range(7)), 3'($urandom_range(7)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        5: load_settings($urandom_range(500000, 1), $urandom_range(500000, 1),
                         3'($urandom_range(7)), 3'($urandom_range(7)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        6: load_settings(4, 250000, 3'd3, 3'd3, 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
        default: load_settings($urandom_range(2000, 1), $urandom_range(500000, 100000),
                               3'($urandom_range(7)), 3'($urandom_range(7)),
                               8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)));
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct = 16;
          recv_stall_pct = 16;
        end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) run_session();
    end

    // Let the last words come out, then give the verdict
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
